FILE: sv/spdpi_pkg.sv
// ----------------------------------------------------------------------------
// spdpi_pkg
// Shared widths, register indexes, types and saturation helpers for the
// speed PI controller with slew limit.
// ----------------------------------------------------------------------------
package spdpi_pkg;

   localparam int DATA_W    = 32;
   localparam int COUNT_W   = 16;
   localparam int INTEG_W   = 24;
   localparam int MCHG_W    = 31;
   localparam int CSR_IDX_W = 4;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int MUL_STEPS = DATA_W / 2;   // radix-4 digits of the multiplier
   localparam int STEP_W    = $clog2(MUL_STEPS);
   localparam int QSHIFT    = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SET_SPEED      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_RATIO    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_TO_ANGLE = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_CHANGE     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_ANGLE      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ANGLE      = 4'd7;

   // integrator clamp, +/-80.0 in Q8.16
   localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 24'sd5242880;

   typedef struct packed {
      logic signed [DATA_W-1:0] set_speed;
      logic signed [DATA_W-1:0] speed_ratio;
      logic signed [DATA_W-1:0] prop_gain;
      logic signed [DATA_W-1:0] integ_gain;
      logic signed [DATA_W-1:0] speed_to_angle;
      logic        [MCHG_W-1:0] max_change;
      logic signed [DATA_W-1:0] min_angle;
      logic signed [DATA_W-1:0] max_angle;
   } cfg_type;

   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] mcand;
      logic signed [DATA_W-1:0] mplier;
   } mul_cmd_type;

   typedef struct packed {
      logic                     done;
      logic signed [PROD_W-1:0] prod;
   } mul_rsp_type;

   // integer product saturated to 32 bits
   function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [PROD_W-1:0] p);
      logic same;
      begin
         same = (&p[PROD_W-1:DATA_W-1]) | ~(|p[PROD_W-1:DATA_W-1]);
         if (same) begin
            sat_prod = p[DATA_W-1:0];
         end else if (p[PROD_W-1]) begin
            sat_prod = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            sat_prod = {1'b0, {(DATA_W-1){1'b1}}};
         end
      end
   endfunction

   // Q16.16 product: floor shift by 16, then saturate to 32 bits
   function automatic logic signed [DATA_W-1:0] sat_qprod(input logic signed [PROD_W-1:0] p);
      logic same;
      begin
         same = (&p[PROD_W-1:DATA_W+QSHIFT-1]) | ~(|p[PROD_W-1:DATA_W+QSHIFT-1]);
         if (same) begin
            sat_qprod = p[DATA_W+QSHIFT-1:QSHIFT];
         end else if (p[PROD_W-1]) begin
            sat_qprod = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            sat_qprod = {1'b0, {(DATA_W-1){1'b1}}};
         end
      end
   endfunction

   // 33-bit sum saturated to 32 bits
   function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W:0] v);
      begin
         if (v[DATA_W] == v[DATA_W-1]) begin
            sat_sum = v[DATA_W-1:0];
         end else if (v[DATA_W]) begin
            sat_sum = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            sat_sum = {1'b0, {(DATA_W-1){1'b1}}};
         end
      end
   endfunction

endpackage

FILE: sv/spdpi_if.sv
// ----------------------------------------------------------------------------
// spdpi_if
// Valid/ready channels of the speed PI controller: count words in,
// demand words out.
// ----------------------------------------------------------------------------
interface spdpi_req_if;
   import spdpi_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COUNT_W-1:0] speed_count;

   modport source (output valid, output speed_count, input ready);
   modport sink   (input valid, input speed_count, output ready);
endinterface

interface spdpi_rsp_if;
   import spdpi_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  angle_demand;
   logic signed [INTEG_W-1:0] integral_value;

   modport source (output valid, output angle_demand, output integral_value, input ready);
   modport sink   (input valid, input angle_demand, input integral_value, output ready);
endinterface

FILE: sv/spdpi_regs.sv
// ----------------------------------------------------------------------------
// spdpi_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module spdpi_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [spdpi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spdpi_pkg::DATA_W-1:0]     csr_data,
   output spdpi_pkg::cfg_type               cfg
);
   import spdpi_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode one write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_SET_SPEED:      cfg_in.set_speed      = csr_data;
            REG_SPEED_RATIO:    cfg_in.speed_ratio    = csr_data;
            REG_PROP_GAIN:      cfg_in.prop_gain      = csr_data;
            REG_INTEG_GAIN:     cfg_in.integ_gain     = csr_data;
            REG_SPEED_TO_ANGLE: cfg_in.speed_to_angle = csr_data;
            REG_MAX_CHANGE:     cfg_in.max_change     = csr_data[MCHG_W-1:0];
            REG_MIN_ANGLE:      cfg_in.min_angle      = csr_data;
            REG_MAX_ANGLE:      cfg_in.max_angle      = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_speed      <= 32'sd9830400;
         cfg_ff.speed_ratio    <= 32'sd65536;
         cfg_ff.prop_gain      <= '0;
         cfg_ff.integ_gain     <= '0;
         cfg_ff.speed_to_angle <= 32'sd65536;
         cfg_ff.max_change     <= 31'd65536;
         cfg_ff.min_angle      <= -32'sd1966080;
         cfg_ff.max_angle      <= 32'sd1966080;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/spdpi_mul.sv
// ----------------------------------------------------------------------------
// spdpi_mul
// Signed 32x32 digit-serial multiplier: the multiplier is shifted out two
// bits per cycle (radix 4, top digit signed), 16 steps per product.
// ----------------------------------------------------------------------------
module spdpi_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  spdpi_pkg::mul_cmd_type cmd,
   output spdpi_pkg::mul_rsp_type rsp
);
   import spdpi_pkg::*;

   localparam int ACC_W = DATA_W + 3;

   logic                     busy_ff,  busy_in;
   logic                     done_ff,  done_in;
   logic [STEP_W-1:0]        cnt_ff,   cnt_in;
   logic signed [DATA_W-1:0] a_ff,     a_in;
   logic signed [DATA_W+1:0] a3_ff,    a3_in;
   logic [DATA_W-1:0]        b_ff,     b_in;
   logic signed [ACC_W-1:0]  acc_ff,   acc_in;
   logic [DATA_W-1:0]        lo_ff,    lo_in;

   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  sum;
   logic                     last_step;

   assign last_step = (cnt_ff == STEP_W'(MUL_STEPS - 1));

   // partial product for the current digit
   always_comb begin
      case (b_ff[1:0])
         2'b00: addend = '0;
         2'b01: addend = ACC_W'(a_ff);
         2'b10: addend = last_step ? -(ACC_W'(a_ff) <<< 1) : (ACC_W'(a_ff) <<< 1);
         2'b11: addend = last_step ? -ACC_W'(a_ff) : ACC_W'(a3_ff);
         default: addend = '0;
      endcase
      sum = acc_ff + addend;
   end

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      a3_in   = a3_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = cmd.mcand;
         a3_in   = ((DATA_W+2)'(cmd.mcand) <<< 1) + (DATA_W+2)'(cmd.mcand);
         b_in    = cmd.mplier;
         acc_in  = '0;
         lo_in   = '0;
      end else if (busy_ff) begin
         acc_in = {{2{sum[ACC_W-1]}}, sum[ACC_W-1:2]};
         lo_in  = {sum[1:0], lo_ff[DATA_W-1:2]};
         b_in   = {2'b00, b_ff[DATA_W-1:2]};
         cnt_in = cnt_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      a3_ff  <= a3_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = {acc_ff[DATA_W-1:0], lo_ff};

endmodule

FILE: sv/speed_pi_with_slew_limit.sv
// ----------------------------------------------------------------------------
// speed_pi_with_slew_limit
// Each accepted count word runs to its demand word through four products on
//   the shared digit-serial multiplier (16 digit steps and a done strobe
//   each), the sequencer states between them and any wait for the output slot.
// Flow: one word at a time; the next count word is taken
//   once the sequencer is back in idle, even while a demand word waits.
// Reset: synchronous, active high; registers to defaults, integrator and
//   last demand to zero, output empty.
// ----------------------------------------------------------------------------
module speed_pi_with_slew_limit (
   input  logic                             clock,
   input  logic                             reset,
   spdpi_req_if.sink                        req,
   spdpi_rsp_if.source                      rsp,
   input  logic                             csr_wr_en,
   input  logic [spdpi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spdpi_pkg::DATA_W-1:0]     csr_data
);
   import spdpi_pkg::*;

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SPD    = 4'd1;
   localparam logic [3:0] ST_ERR    = 4'd2;
   localparam logic [3:0] ST_KI_GO  = 4'd3;
   localparam logic [3:0] ST_KI     = 4'd4;
   localparam logic [3:0] ST_INTG   = 4'd5;
   localparam logic [3:0] ST_KP     = 4'd6;
   localparam logic [3:0] ST_CTRL   = 4'd7;
   localparam logic [3:0] ST_ANG_GO = 4'd8;
   localparam logic [3:0] ST_ANG    = 4'd9;
   localparam logic [3:0] ST_SLEW   = 4'd10;
   localparam logic [3:0] ST_CLAMP  = 4'd11;
   localparam logic [3:0] ST_OUT    = 4'd12;

   cfg_type     cfg;
   mul_cmd_type mul_cmd;
   mul_rsp_type mul_rsp;

   logic [3:0]                state_ff,   state_in;
   logic signed [DATA_W-1:0]  speed_ff,   speed_in;
   logic signed [DATA_W-1:0]  err_ff,     err_in;
   logic signed [DATA_W-1:0]  pki_ff,     pki_in;
   logic signed [DATA_W-1:0]  pkp_ff,     pkp_in;
   logic signed [INTEG_W-1:0] integ_ff,   integ_in;
   logic signed [DATA_W-1:0]  ctrl_ff,    ctrl_in;
   logic signed [DATA_W-1:0]  dem_ff,     dem_in;
   logic signed [DATA_W-1:0]  last_ff,    last_in;
   logic signed [DATA_W:0]    up_ff,      up_in;
   logic signed [DATA_W:0]    dn_ff,      dn_in;
   logic                      hi_ff,      hi_in;
   logic                      lo_ff,      lo_in;
   logic                      rvalid_ff,  rvalid_in;
   logic signed [DATA_W-1:0]  rdem_ff,    rdem_in;
   logic signed [INTEG_W-1:0] rint_ff,    rint_in;

   logic signed [DATA_W:0]    err_wide;
   logic signed [DATA_W:0]    integ_sum;
   logic signed [DATA_W:0]    ctrl_sum;
   logic signed [DATA_W:0]    diff;
   logic signed [DATA_W:0]    mc_wide;
   logic signed [DATA_W-1:0]  lim;
   logic signed [DATA_W-1:0]  lim_lo;
   logic                      slot_free;

   spdpi_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   spdpi_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign slot_free = !rvalid_ff || rsp.ready;

   // datapath helpers
   always_comb begin
      err_wide  = (DATA_W+1)'(cfg.set_speed) - (DATA_W+1)'(speed_ff);
      integ_sum = (DATA_W+1)'(integ_ff) + (DATA_W+1)'(pki_ff);
      ctrl_sum  = (DATA_W+1)'(pkp_ff) + (DATA_W+1)'(integ_ff);
      mc_wide   = {2'b00, cfg.max_change};
      diff      = (DATA_W+1)'(dem_ff) - (DATA_W+1)'(last_ff);
      if (hi_ff) begin
         lim = up_ff[DATA_W-1:0];
      end else if (lo_ff) begin
         lim = dn_ff[DATA_W-1:0];
      end else begin
         lim = dem_ff;
      end
      // raise to min first, then lower to max: max wins on inverted bounds
      lim_lo = (lim < cfg.min_angle) ? cfg.min_angle : lim;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      speed_in  = speed_ff;
      err_in    = err_ff;
      pki_in    = pki_ff;
      pkp_in    = pkp_ff;
      integ_in  = integ_ff;
      ctrl_in   = ctrl_ff;
      dem_in    = dem_ff;
      last_in   = last_ff;
      up_in     = up_ff;
      dn_in     = dn_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      rdem_in   = rdem_ff;
      rint_in   = rint_ff;
      rvalid_in = rvalid_ff && !rsp.ready;
      mul_cmd.start  = 1'b0;
      mul_cmd.mcand  = cfg.speed_ratio;
      mul_cmd.mplier = DATA_W'(req.speed_count);

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               mul_cmd.start = 1'b1;
               state_in      = ST_SPD;
            end
         end
         ST_SPD: begin
            if (mul_rsp.done) begin
               speed_in = sat_prod(mul_rsp.prod);
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            err_in   = sat_sum(err_wide);
            state_in = ST_KI_GO;
         end
         ST_KI_GO: begin
            mul_cmd.start  = 1'b1;
            mul_cmd.mcand  = cfg.integ_gain;
            mul_cmd.mplier = err_ff;
            state_in       = ST_KI;
         end
         ST_KI: begin
            if (mul_rsp.done) begin
               pki_in   = sat_qprod(mul_rsp.prod);
               state_in = ST_INTG;
            end
         end
         ST_INTG: begin
            // clamp integrator and start the proportional product
            if (integ_sum > (DATA_W+1)'(INTEG_LIMIT)) begin
               integ_in = INTEG_LIMIT;
            end else if (integ_sum < -(DATA_W+1)'(INTEG_LIMIT)) begin
               integ_in = -INTEG_LIMIT;
            end else begin
               integ_in = integ_sum[INTEG_W-1:0];
            end
            mul_cmd.start  = 1'b1;
            mul_cmd.mcand  = cfg.prop_gain;
            mul_cmd.mplier = err_ff;
            state_in       = ST_KP;
         end
         ST_KP: begin
            if (mul_rsp.done) begin
               pkp_in   = sat_qprod(mul_rsp.prod);
               state_in = ST_CTRL;
            end
         end
         ST_CTRL: begin
            ctrl_in  = sat_sum(ctrl_sum);
            state_in = ST_ANG_GO;
         end
         ST_ANG_GO: begin
            mul_cmd.start  = 1'b1;
            mul_cmd.mcand  = cfg.speed_to_angle;
            mul_cmd.mplier = ctrl_ff;
            state_in       = ST_ANG;
         end
         ST_ANG: begin
            if (mul_rsp.done) begin
               dem_in   = sat_qprod(mul_rsp.prod);
               state_in = ST_SLEW;
            end
         end
         ST_SLEW: begin
            // slew limits around the previous demand
            hi_in    = diff > mc_wide;
            lo_in    = diff < -mc_wide;
            up_in    = (DATA_W+1)'(last_ff) + mc_wide;
            dn_in    = (DATA_W+1)'(last_ff) - mc_wide;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            last_in  = (lim_lo > cfg.max_angle) ? cfg.max_angle : lim_lo;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               rdem_in   = last_ff;
               rint_in   = integ_ff;
               rvalid_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
         integ_ff  <= '0;
         last_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         integ_ff  <= integ_in;
         last_ff   <= last_in;
      end
      speed_ff <= speed_in;
      err_ff   <= err_in;
      pki_ff   <= pki_in;
      pkp_ff   <= pkp_in;
      ctrl_ff  <= ctrl_in;
      dem_ff   <= dem_in;
      up_ff    <= up_in;
      dn_ff    <= dn_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      rdem_ff  <= rdem_in;
      rint_ff  <= rint_in;
   end

   assign rsp.valid          = rvalid_ff;
   assign rsp.angle_demand   = rdem_ff;
   assign rsp.integral_value = rint_ff;

endmodule
